// ===== rtl/fsst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsst_pkg
// shared constants, frame phase codes and helpers for the scancode
// serial transmitter
// ----------------------------------------------------------------------------
package fsst_pkg;

	// queue geometry, one slot always stays empty
	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	// serial frame
	localparam int SCANCODE_W = 8;
	localparam int DATA_BITS  = 8;
	localparam int BIT_IDX_W  = $clog2(DATA_BITS);
	localparam int BIT_CNT_W  = 4;

	// request kinds
	localparam logic REQ_ENQUEUE = 1'b0;
	localparam logic REQ_CLK_EDGE = 1'b1;

	// frame phase codes
	localparam int PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_START  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_DATA   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_STOP   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_RETURN = 3'd4;

	typedef logic [PTR_W-1:0] ptr_t;

	// circular increment, safe for depths that are not a power of two
	function automatic ptr_t next_slot(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(FIFO_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/fsst_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsst request and response channels
// valid/ready channels carrying one request or one line step result
// ----------------------------------------------------------------------------
interface fsst_req_if;
	logic                             valid;
	logic                             ready;
	logic                             req_type;
	logic [fsst_pkg::SCANCODE_W-1:0]  scancode;

	modport source (output valid, output req_type, output scancode, input ready);
	modport sink   (input valid, input req_type, input scancode, output ready);
endinterface

interface fsst_rsp_if;
	logic valid;
	logic ready;
	logic data_level;
	logic dropped;

	modport source (output valid, output data_level, output dropped, input ready);
	modport sink   (input valid, input data_level, input dropped, output ready);
endinterface

// ===== rtl/fifo_scancode_serial_transmitter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_scancode_serial_transmitter_core
// serial scancode transmitter fed by a circular byte queue
// ----------------------------------------------------------------------------
// req channel: each transaction is an enqueue (req_type = 0) that queues
//   scancode, or one falling host clock edge (req_type = 1) that advances
//   the serial frame by one step
// rsp channel: one transaction per request, the data line level after that
//   step and a dropped flag for an enqueue into a full queue (one slot always
//   stays empty, so FIFO_DEPTH-1 bytes fit)
// frame: sync mark high on pop, start bit 0, eight data bits lsb first, stop
//   bit 1, then back low; a queued byte starts the next frame on that return
// timing: an accepted request waits in the input register, the state and the
//   output register are updated together from it, and one request per cycle
//   is sustained while rsp is not stalled, set by the single update stage
//   between the input register and the output register
// reset: arst_n clears pointers, frame phase, bit counter, tx byte and line
//   level; the queue storage itself is not cleared
// stall: while rsp is stalled the output register holds, one more request
//   waits in the input register, after which req.ready drops
// ----------------------------------------------------------------------------
module fifo_scancode_serial_transmitter_core (
	input  logic           clk,
	input  logic           arst_n,
	fsst_req_if.sink       req,
	fsst_rsp_if.source     rsp
);

	// input register stage
	logic                             valid_s1;
	logic                             req_type_s1;
	logic [fsst_pkg::SCANCODE_W-1:0]  scancode_s1;
	logic                             fire_s1;

	// transmitter state
	logic [fsst_pkg::SCANCODE_W-1:0]  store_q [fsst_pkg::FIFO_DEPTH];
	fsst_pkg::ptr_t                   wr_ptr_q, rd_ptr_q;
	logic [fsst_pkg::PHASE_W-1:0]     phase_q;
	logic [fsst_pkg::BIT_CNT_W-1:0]   bit_cnt_q;
	logic [fsst_pkg::SCANCODE_W-1:0]  tx_byte_q;
	logic                             line_q;

	// next state
	fsst_pkg::ptr_t                   wr_ptr_d, rd_ptr_d, wr_nxt, rd_nxt;
	logic [fsst_pkg::PHASE_W-1:0]     phase_d;
	logic [fsst_pkg::BIT_CNT_W-1:0]   bit_cnt_d, bit_cnt_inc;
	logic [fsst_pkg::SCANCODE_W-1:0]  tx_byte_d, head_byte, enq_head;
	logic                             line_d;
	logic                             drop_d;
	logic                             store_we;
	logic                             q_full, q_empty;

	// output register
	logic                             rsp_valid_q;
	logic                             data_level_q;
	logic                             dropped_q;

	// stage advances when the output register is free or being emptied
	assign fire_s1   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			scancode_s1 <= req.scancode;
		end
	end

	// queue status and head byte; an empty queue bypasses the incoming byte
	assign wr_nxt      = fsst_pkg::next_slot(wr_ptr_q);
	assign rd_nxt      = fsst_pkg::next_slot(rd_ptr_q);
	assign q_full      = (wr_nxt == rd_ptr_q);
	assign q_empty     = (wr_ptr_q == rd_ptr_q);
	assign head_byte   = store_q[rd_ptr_q];
	assign enq_head    = q_empty ? scancode_s1 : head_byte;
	assign bit_cnt_inc = bit_cnt_q + 1'b1;

	always_comb begin
		wr_ptr_d  = wr_ptr_q;
		rd_ptr_d  = rd_ptr_q;
		phase_d   = phase_q;
		bit_cnt_d = bit_cnt_q;
		tx_byte_d = tx_byte_q;
		line_d    = line_q;
		drop_d    = 1'b0;
		store_we  = 1'b0;
		if (req_type_s1 == fsst_pkg::REQ_ENQUEUE) begin
			if (q_full) begin
				// full queue: byte discarded, nothing else moves
				drop_d = 1'b1;
			end else begin
				store_we = 1'b1;
				wr_ptr_d = wr_nxt;
				if (phase_q == fsst_pkg::PH_IDLE) begin
					// pop at once and raise the sync mark
					tx_byte_d = enq_head;
					rd_ptr_d  = rd_nxt;
					line_d    = 1'b1;
					phase_d   = fsst_pkg::PH_START;
				end
			end
		end else begin
			unique case (phase_q)
				fsst_pkg::PH_START: begin
					line_d    = 1'b0;
					bit_cnt_d = '0;
					phase_d   = fsst_pkg::PH_DATA;
				end
				fsst_pkg::PH_DATA: begin
					line_d    = tx_byte_q[bit_cnt_q[fsst_pkg::BIT_IDX_W-1:0]];
					bit_cnt_d = bit_cnt_inc;
					if (bit_cnt_inc >= fsst_pkg::BIT_CNT_W'(fsst_pkg::DATA_BITS)) begin
						phase_d = fsst_pkg::PH_STOP;
					end
				end
				fsst_pkg::PH_STOP: begin
					line_d  = 1'b1;
					phase_d = fsst_pkg::PH_RETURN;
				end
				fsst_pkg::PH_RETURN: begin
					line_d  = 1'b0;
					phase_d = fsst_pkg::PH_IDLE;
					// back-to-back frame when a byte is waiting
					if (!q_empty) begin
						tx_byte_d = head_byte;
						rd_ptr_d  = rd_nxt;
						line_d    = 1'b1;
						phase_d   = fsst_pkg::PH_START;
					end
				end
				default: begin
					// idle or unused phase: clock edge ignored
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			phase_q   <= fsst_pkg::PH_IDLE;
			bit_cnt_q <= '0;
			tx_byte_q <= '0;
			line_q    <= 1'b0;
		end else if (fire_s1) begin
			wr_ptr_q  <= wr_ptr_d;
			rd_ptr_q  <= rd_ptr_d;
			phase_q   <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			tx_byte_q <= tx_byte_d;
			line_q    <= line_d;
		end
	end

	// queue storage, no reset
	always_ff @(posedge clk) begin
		if (fire_s1 && store_we) begin
			store_q[wr_ptr_q] <= scancode_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			data_level_q <= line_d;
			dropped_q    <= drop_d;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.data_level = data_level_q;
	assign rsp.dropped    = dropped_q;

`ifndef SYNTHESIS
	// an idle transmitter never leaves a byte waiting in the queue
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == fsst_pkg::PH_IDLE) |-> (wr_ptr_q == rd_ptr_q))
		else $error("idle with bytes still queued");

	// the data bit counter never runs past one byte
	a_bit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= fsst_pkg::BIT_CNT_W'(fsst_pkg::DATA_BITS))
		else $error("bit counter overran");

	// only the five defined frame phases are ever reached
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= fsst_pkg::PH_RETURN)
		else $error("frame phase left its range");

	// a clock edge while idle leaves the line alone
	a_idle_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && (req_type_s1 == fsst_pkg::REQ_CLK_EDGE)
			&& (phase_q == fsst_pkg::PH_IDLE)) |=> (line_q == $past(line_q)))
		else $error("idle clock edge moved the line");

	// a dropped enqueue never starts a frame or moves a pointer
	a_drop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && drop_d) |=> ($stable(wr_ptr_q) && $stable(rd_ptr_q)))
		else $error("dropped byte changed the queue");
`endif

endmodule
